// File: rtl/core/segw_pkg.sv
package segw_pkg;

    localparam int LINE_LIMIT = 1568;
    localparam int LINES_W    = 16;
    localparam int TIME_W     = 32;
    localparam int GAIN_W     = 13;
    localparam int BYTE_W     = 8;
    localparam int QUEUE_D    = 3;
    localparam int QCNT_W     = 2;
    localparam int DIV_STEPS  = TIME_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
    localparam int PADDR_W    = 3;

    localparam logic [LINES_W-1:0] LINES_MIN = LINES_W'(2);
    localparam logic [LINES_W-1:0] LINES_MAX = LINES_W'(LINE_LIMIT - 4);

    localparam logic [GAIN_W-1:0] GAIN_ONE     = GAIN_W'(256);
    localparam logic [GAIN_W-1:0] GAIN_SIXTEEN = GAIN_W'(4096);

    localparam logic [BYTE_W-1:0] ADDR_GAIN     = 8'h00;
    localparam logic [BYTE_W-1:0] ADDR_LINES_LO = 8'h01;
    localparam logic [BYTE_W-1:0] ADDR_LINES_HI = 8'h02;
    localparam logic [BYTE_W-1:0] ADDR_MODE     = 8'h12;
    localparam logic [BYTE_W-1:0] MODE_STREAM   = 8'h00;
    localparam logic [BYTE_W-1:0] MODE_STANDBY  = 8'h40;
    localparam logic [BYTE_W-1:0] COPY_RESET    = 8'hFF;

    // register index = paddr[2]
    localparam logic REG_EXPOSURE_MIN = 1'b0;
    localparam logic REG_EXPOSURE_MAX = 1'b1;

    typedef enum logic [1:0] {
        OP_EXPOSURE = 2'd0,
        OP_GAIN     = 2'd1,
        OP_BOTH     = 2'd2,
        OP_ENABLE   = 2'd3
    } op_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic eval;
    } cmd_t;

    typedef struct packed {
        logic use_exp;
        logic div_busy;
        logic q_empty;
    } status_t;

endpackage

// File: rtl/core/segw_if.sv
interface segw_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] exposure_time;
    logic [12:0] gain_value;
    logic        stream_on;

    modport source (output valid, opcode, exposure_time, gain_value, stream_on, input ready);
    modport sink (input valid, opcode, exposure_time, gain_value, stream_on, output ready);
endinterface

interface segw_wr_if;
    logic       valid;
    logic       ready;
    logic [7:0] reg_address;
    logic [7:0] reg_data;
    logic       last_write;

    modport source (output valid, reg_address, reg_data, last_write, input ready);
    modport sink (input valid, reg_address, reg_data, last_write, output ready);
endinterface

// File: rtl/core/segw_div.sv
module segw_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [31:0] quotient
);
    import segw_pkg::*;

    logic [TIME_W-1:0]    quo_reg, quo_next;
    logic [TIME_W-1:0]    rem_reg, rem_next;
    logic [TIME_W-1:0]    dsr_reg, dsr_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [TIME_W:0]      shifted;
    logic [TIME_W:0]      diff;

    // restoring divide, one quotient bit per cycle; divisor zero gives all ones
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[TIME_W-1]};
        diff     = shifted - {1'b0, dsr_reg};
        quo_next = quo_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
            cnt_next = DIV_CNT_W'(DIV_STEPS);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (shifted >= {1'b0, dsr_reg})
            begin
                rem_next = diff[TIME_W-1:0];
                quo_next = {quo_reg[TIME_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[TIME_W-1:0];
                quo_next = {quo_reg[TIME_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

endmodule

// File: rtl/core/segw_dp.sv
module segw_dp (
    input  logic             clk,
    input  logic             rst_n,
    input  segw_pkg::cmd_t   cmd,
    output segw_pkg::status_t status,
    input  logic [31:0]      exposure_min,
    input  logic [31:0]      exposure_max,
    input  logic [1:0]       opcode,
    input  logic [31:0]      exposure_time,
    input  logic [12:0]      gain_value,
    input  logic             stream_on,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       reg_address,
    output logic [7:0]       reg_data,
    output logic             last_write
);
    import segw_pkg::*;

    op_t               op_reg;
    logic [TIME_W-1:0] time_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic              on_reg;

    logic [BYTE_W-1:0] hi_copy_reg, hi_copy_next;
    logic [BYTE_W-1:0] lo_copy_reg, lo_copy_next;
    logic [BYTE_W-1:0] gain_copy_reg, gain_copy_next;

    logic [BYTE_W-1:0] q_addr_reg [QUEUE_D];
    logic [BYTE_W-1:0] q_data_reg [QUEUE_D];
    logic [BYTE_W-1:0] q_addr_next [QUEUE_D];
    logic [BYTE_W-1:0] q_data_next [QUEUE_D];
    logic [QCNT_W-1:0] q_cnt_reg, q_cnt_next;

    logic [TIME_W-1:0]  t_lo, t_clamp;
    logic               div_busy;
    logic [TIME_W-1:0]  quotient;
    logic [LINES_W-1:0] lines;
    logic [BYTE_W-1:0]  hi, lo;
    logic [GAIN_W-1:0]  g_clamp;
    logic [4:0]         whole;
    logic [2:0]         idx;
    logic [GAIN_W-1:0]  g_off;
    logic [3:0]         frac;
    logic [BYTE_W-1:0]  code;
    logic               use_exp, use_gain, exp_wr, gain_wr, out_beat;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op_t'(opcode);
            time_reg <= exposure_time;
            gain_reg <= gain_value;
            on_reg   <= stream_on;
        end
    end

    // min clamp first, then max, so max wins when max < min
    always_comb
    begin
        t_lo    = (time_reg < exposure_min) ? exposure_min : time_reg;
        t_clamp = (t_lo > exposure_max) ? exposure_max : t_lo;
    end

    segw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (t_clamp),
        .divisor  (exposure_min),
        .busy     (div_busy),
        .quotient (quotient)
    );

    always_comb
    begin
        if (quotient < TIME_W'(LINES_MIN))
            lines = LINES_MIN;
        else if (quotient > TIME_W'(LINES_MAX))
            lines = LINES_MAX;
        else
            lines = quotient[LINES_W-1:0];
        hi = lines[15:8];
        lo = lines[7:0];
    end

    // gain: Q5.8 clamp, octave index, 4-bit fraction within the octave
    always_comb
    begin
        if (gain_reg < GAIN_ONE)
            g_clamp = GAIN_ONE;
        else if (gain_reg > GAIN_SIXTEEN)
            g_clamp = GAIN_SIXTEEN;
        else
            g_clamp = gain_reg;
        whole = g_clamp[12:8];
        priority if (whole >= 5'd16)
            idx = 3'd4;
        else if (whole >= 5'd8)
            idx = 3'd3;
        else if (whole >= 5'd4)
            idx = 3'd2;
        else if (whole >= 5'd2)
            idx = 3'd1;
        else
            idx = 3'd0;
        g_off = g_clamp - (GAIN_ONE << idx);
        unique case (idx)
            3'd0:    frac = g_off[7:4];
            3'd1:    frac = g_off[8:5];
            3'd2:    frac = g_off[9:6];
            3'd3:    frac = g_off[10:7];
            default: frac = g_off[11:8];
        endcase
        code = {1'b0, idx, frac};
    end

    assign use_exp  = (op_reg == OP_EXPOSURE) || (op_reg == OP_BOTH);
    assign use_gain = (op_reg == OP_GAIN) || (op_reg == OP_BOTH);
    assign exp_wr   = use_exp && ((hi != hi_copy_reg) || (lo != lo_copy_reg));
    assign gain_wr  = use_gain && (code != gain_copy_reg);
    assign out_beat = out_valid && out_ready;

    always_comb
    begin
        hi_copy_next   = hi_copy_reg;
        lo_copy_next   = lo_copy_reg;
        gain_copy_next = gain_copy_reg;
        q_addr_next    = q_addr_reg;
        q_data_next    = q_data_reg;
        q_cnt_next     = q_cnt_reg;
        if (cmd.eval)
        begin
            if (op_reg == OP_ENABLE)
            begin
                q_addr_next[0] = ADDR_MODE;
                q_data_next[0] = on_reg ? MODE_STREAM : MODE_STANDBY;
                q_cnt_next     = QCNT_W'(1);
            end
            else
            begin
                if (exp_wr)
                begin
                    hi_copy_next   = hi;
                    lo_copy_next   = lo;
                    q_addr_next[0] = ADDR_LINES_HI;
                    q_data_next[0] = hi;
                    q_addr_next[1] = ADDR_LINES_LO;
                    q_data_next[1] = lo;
                end
                if (gain_wr)
                begin
                    gain_copy_next = code;
                    if (exp_wr)
                    begin
                        q_addr_next[2] = ADDR_GAIN;
                        q_data_next[2] = code;
                    end
                    else
                    begin
                        q_addr_next[0] = ADDR_GAIN;
                        q_data_next[0] = code;
                    end
                end
                q_cnt_next = {exp_wr, 1'b0} + {1'b0, gain_wr};
            end
        end
        else if (out_beat)
        begin
            q_addr_next[0] = q_addr_reg[1];
            q_data_next[0] = q_data_reg[1];
            q_addr_next[1] = q_addr_reg[2];
            q_data_next[1] = q_data_reg[2];
            q_cnt_next     = q_cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hi_copy_reg   <= COPY_RESET;
            lo_copy_reg   <= COPY_RESET;
            gain_copy_reg <= COPY_RESET;
            q_cnt_reg     <= '0;
        end
        else
        begin
            hi_copy_reg   <= hi_copy_next;
            lo_copy_reg   <= lo_copy_next;
            gain_copy_reg <= gain_copy_next;
            q_cnt_reg     <= q_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_addr_reg <= q_addr_next;
        q_data_reg <= q_data_next;
    end

    assign out_valid   = (q_cnt_reg != '0);
    assign reg_address = q_addr_reg[0];
    assign reg_data    = q_data_reg[0];
    assign last_write  = (q_cnt_reg == QCNT_W'(1));

    assign status.use_exp  = use_exp;
    assign status.div_busy = div_busy;
    assign status.q_empty  = (q_cnt_reg == '0);

endmodule

// File: rtl/core/segw_ctrl.sv
module segw_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  segw_pkg::status_t status,
    output segw_pkg::cmd_t    cmd
);
    import segw_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_START = 5'b00010,
        ST_DIV   = 5'b00100,
        ST_EVAL  = 5'b01000,
        ST_DRAIN = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd.load      = 1'b0;
        cmd.div_start = 1'b0;
        cmd.eval      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                if (in_valid)
                    state_next = ST_START;
            end
            ST_START:
            begin
                if (status.use_exp)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                    state_next = ST_EVAL;
            end
            ST_DIV:
            begin
                if (!status.div_busy)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (status.q_empty)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef SYNTHESIS
    a_ready_queue_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> status.q_empty)
        else $error("input taken while writes pending");
    a_start_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !status.div_busy)
        else $error("divider started while busy");
    a_div_done_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && !status.div_busy) |=> cmd.eval)
        else $error("eval missed after divide");
    a_eval_queue_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eval |-> status.q_empty)
        else $error("queue loaded over pending writes");
`endif

endmodule

// File: rtl/core/sensor_exposure_gain_writer_unit.sv
// Sequence: an accepted exposure command passes through setup, the bit-serial line
// divide (incl. done check) and eval before its first write; gain/enable commands
// skip the divide. Then one beat per sensor write (0 to 3).
// A new command is taken once all writes drained.
// Reset (rst_n, async low): exposure_min = 1, exposure_max = all ones, copies = 0xFF.
module sensor_exposure_gain_writer_unit (
    input  logic        clk,
    input  logic        rst_n,
    segw_req_if.sink    req,
    segw_wr_if.source   wr,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import segw_pkg::*;

    logic [TIME_W-1:0] exposure_min_reg, exposure_min_next;
    logic [TIME_W-1:0] exposure_max_reg, exposure_max_next;
    logic              cfg_wr;
    cmd_t              cmd;
    status_t           status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        exposure_min_next = exposure_min_reg;
        exposure_max_next = exposure_max_reg;
        if (cfg_wr)
        begin
            if (paddr[2] == REG_EXPOSURE_MIN)
                exposure_min_next = pwdata;
            else
                exposure_max_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exposure_min_reg <= TIME_W'(1);
            exposure_max_reg <= '1;
        end
        else
        begin
            exposure_min_reg <= exposure_min_next;
            exposure_max_reg <= exposure_max_next;
        end
    end

    assign prdata = (paddr[2] == REG_EXPOSURE_MAX) ? exposure_max_reg : exposure_min_reg;

    segw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .status   (status),
        .cmd      (cmd)
    );

    segw_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .exposure_min  (exposure_min_reg),
        .exposure_max  (exposure_max_reg),
        .opcode        (req.opcode),
        .exposure_time (req.exposure_time),
        .gain_value    (req.gain_value),
        .stream_on     (req.stream_on),
        .out_valid     (wr.valid),
        .out_ready     (wr.ready),
        .reg_address   (wr.reg_address),
        .reg_data      (wr.reg_data),
        .last_write    (wr.last_write)
    );

endmodule
